@@ rtl/dewu_pkg.sv @@
`default_nettype none

package dewu_pkg;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CRATE_MATCH  = 2'd0,
        REG_SLOT_MATCH   = 2'd1,
        REG_CHANNEL_MASK = 2'd2
    } reg_index_t;

    localparam int unsigned WORD_W    = 16;
    localparam int unsigned CHANNEL_W = 5;
    localparam int unsigned VALUE_W   = 12;
    localparam int unsigned CRATE_W   = 8;
    localparam int unsigned SLOT_W    = 5;
    localparam int unsigned COUNT_W   = 6;

    localparam logic [2:0] TYPE_HEADER = 3'd2;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_COUNT  = 3'd1,
        PH_CHAN   = 3'd2,
        PH_VALUE  = 3'd3,
        PH_TRAIL1 = 3'd4,
        PH_TRAIL2 = 3'd5
    } phase_t;

    typedef struct packed {
        logic [CRATE_W-1:0] crate;
        logic [SLOT_W-1:0]  slot;
    } cfg_t;

    typedef struct packed {
        logic                 hit;
        logic [CHANNEL_W-1:0] channel;
        logic [VALUE_W-1:0]   value;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/dewu_if.sv @@
`default_nettype none

interface dewu_word_if
    import dewu_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

interface dewu_result_if
    import dewu_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CHANNEL_W-1:0] channel;
    logic [VALUE_W-1:0]   value;

    modport source (output valid, output channel, output value, input ready);
    modport sink   (input valid, input channel, input value, output ready);
endinterface

`default_nettype wire

@@ rtl/dewu_cfg_regs.sv @@
`default_nettype none

module dewu_cfg_regs
    import dewu_pkg::*;
#(
    parameter int unsigned CHANNELS = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                       cfg,
    output logic [CHANNELS-1:0]        mask
);

    cfg_t                cfg_reg;
    cfg_t                cfg_next;
    logic [CHANNELS-1:0] mask_reg;
    logic [CHANNELS-1:0] mask_next;

    always_comb
    begin
        cfg_next  = cfg_reg;
        mask_next = mask_reg;
        if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_CRATE_MATCH:  cfg_next.crate = cfg_wdata[CRATE_W-1:0];
                REG_SLOT_MATCH:   cfg_next.slot  = cfg_wdata[SLOT_W-1:0];
                REG_CHANNEL_MASK: mask_next      = cfg_wdata[CHANNELS-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg  <= '0;
            mask_reg <= '0;
        end
        else
        begin
            cfg_reg  <= cfg_next;
            mask_reg <= mask_next;
        end
    end

    assign cfg  = cfg_reg;
    assign mask = mask_reg;

endmodule

`default_nettype wire

@@ rtl/dewu_decoder.sv @@
`default_nettype none

module dewu_decoder
    import dewu_pkg::*;
#(
    parameter int unsigned CHANNELS = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                fire,
    input  wire logic [WORD_W-1:0]   word,
    input  cfg_t                     cfg,
    input  wire logic [CHANNELS-1:0] mask,
    output result_t                  res
);

    localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [COUNT_W-1:0] CHAN_LIMIT = COUNT_W'(CHANNELS);

    phase_t             phase_reg;
    phase_t             phase_next;
    logic [COUNT_W-1:0] remaining_reg;
    logic [COUNT_W-1:0] remaining_next;
    logic [COUNT_W-1:0] chan_reg;
    logic [COUNT_W-1:0] chan_next;

    logic               header_hit;
    logic [COUNT_W-1:0] count_raw;
    logic [COUNT_W-1:0] count_clamped;
    logic [COUNT_W-1:0] remaining_dec;
    logic               mapped;

    // header high: slot 15..11, type 10..8, crate 7..0
    assign header_hit = (word[10:8] == TYPE_HEADER) && (word[7:0] == cfg.crate)
                        && (word[15:11] == cfg.slot);
    assign count_raw     = word[13:8];
    assign count_clamped = (count_raw > CHAN_LIMIT) ? CHAN_LIMIT : count_raw;
    assign remaining_dec = remaining_reg - COUNT_W'(1);
    assign mapped        = (chan_reg < CHAN_LIMIT) && mask[chan_reg[IDX_W-1:0]];

    // next state
    always_comb
    begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        chan_next      = chan_reg;
        if (fire)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (header_hit)
                        phase_next = PH_COUNT;
                end
                PH_COUNT:
                begin
                    remaining_next = count_clamped;
                    phase_next     = (count_clamped == '0) ? PH_TRAIL1 : PH_CHAN;
                end
                PH_CHAN:
                begin
                    chan_next  = word[5:0];
                    phase_next = PH_VALUE;
                end
                PH_VALUE:
                begin
                    remaining_next = remaining_dec;
                    phase_next     = (remaining_dec == '0) ? PH_TRAIL1 : PH_CHAN;
                end
                PH_TRAIL1:
                    phase_next = PH_TRAIL2;
                default:
                    phase_next = PH_IDLE;
            endcase
        end
    end

    // outputs: data low carries underflow 13, overflow 12, value 11..0
    always_comb
    begin
        res.hit     = (phase_reg == PH_VALUE) && mapped && (word[13:12] == 2'b00);
        res.channel = chan_reg[CHANNEL_W-1:0];
        res.value   = word[VALUE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            remaining_reg <= '0;
            chan_reg      <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            chan_reg      <= chan_next;
        end
    end

    a_remaining_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        remaining_reg <= CHAN_LIMIT)
        else $error("pair count above channel count");

    a_pairs_left: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_CHAN || phase_reg == PH_VALUE) |-> remaining_reg != '0)
        else $error("in pair phase with no pairs left");

    a_hit_mapped: assert property (@(posedge clk) disable iff (!rst_n)
        res.hit |-> (phase_reg == PH_VALUE && chan_reg < CHAN_LIMIT))
        else $error("result from unmapped channel or wrong phase");

    a_trailer_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && phase_reg == PH_TRAIL1) |=> phase_reg == PH_TRAIL2)
        else $error("second trailer word skipped");

endmodule

`default_nettype wire

@@ rtl/digitizer_event_word_unpacker.sv @@
`default_nettype none

// Unpacks 16-bit digitizer event words into (channel, value) results. While idle
// it waits for a header of type 2 carrying the configured crate and slot, reads
// the pair count (clamped to CHANNELS) from the next word, then emits one result
// per channel/value pair whose channel is enabled in the mask and whose value has
// neither underflow nor overflow set; two trailer words close the event. One word
// is accepted every cycle while the result register is free or draining; a word's
// result, if any, goes through the input register, which captures the word, then
// combinational decode, and then the result register, which captures the result.
// Configuration must be written only while no word is in flight.

module digitizer_event_word_unpacker
    import dewu_pkg::*;
#(
    parameter int unsigned CHANNELS = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    dewu_word_if.sink                  words,
    dewu_result_if.source              results
);

    cfg_t                 cfg;
    logic [CHANNELS-1:0]  mask;
    result_t              res;

    logic [WORD_W-1:0]    word_reg;
    logic                 stage_valid_reg;
    logic                 stage_valid_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [CHANNEL_W-1:0] out_channel_reg;
    logic [VALUE_W-1:0]   out_value_reg;

    logic                 stage_fire;
    logic                 accept;

    dewu_cfg_regs #(
        .CHANNELS (CHANNELS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg),
        .mask      (mask)
    );

    dewu_decoder #(
        .CHANNELS (CHANNELS)
    ) u_decoder (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (stage_fire),
        .word  (word_reg),
        .cfg   (cfg),
        .mask  (mask),
        .res   (res)
    );

    // the staged word moves on whenever the result register is free or draining
    assign stage_fire  = stage_valid_reg && (!out_valid_reg || results.ready);
    assign words.ready = !stage_valid_reg || stage_fire;
    assign accept      = words.valid && words.ready;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
            stage_valid_next = 1'b1;
        else if (stage_fire)
            stage_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (stage_fire)
            out_valid_next = res.hit;
        else if (results.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            word_reg <= words.word;
        if (stage_fire && res.hit)
        begin
            out_channel_reg <= res.channel;
            out_value_reg   <= res.value;
        end
    end

    assign results.valid   = out_valid_reg;
    assign results.channel = out_channel_reg;
    assign results.value   = out_value_reg;

endmodule

`default_nettype wire
